FILE: rtl/core/slru_pkg.sv
// Types and constants shared by the segmented LRU cache.
// No dependencies.
package slru_pkg;

    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_PUT    = 2'd1;
    localparam logic [1:0] REQ_PROBE  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic CFG_TOTAL     = 1'b0;
    localparam logic CFG_PROTECTED = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic        hit;
        logic        was_protected;
        logic [31:0] read_value;
        logic        miss_error;
        logic        evicted_valid;
        logic [31:0] evicted_key;
        logic [3:0]  occupancy;
    } rsp_word_t;

    // Front words fed into the head cell of each chain.
    typedef struct packed {
        logic [31:0] p_key;
        logic [31:0] p_value;
        logic [31:0] m_key;
        logic [31:0] m_value;
    } slru_cmd_t;

endpackage

FILE: rtl/core/slru_cell.sv
// One storage cell of a recency chain: key, value, and a match flag.
// Depends on slru_pkg.
module slru_cell (
    input  logic        clk,
    input  logic        shift,
    input  logic        pull,
    input  logic [31:0] in_key,
    input  logic [31:0] in_value,
    input  logic [31:0] back_key,
    input  logic [31:0] back_value,
    input  logic [31:0] look_key,
    output logic [31:0] key,
    output logic [31:0] value,
    output logic        match
);
    import slru_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] value_reg;

    // shift takes the front neighbour's word, pull the back neighbour's
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        else if (pull)
        begin
            key_reg   <= back_key;
            value_reg <= back_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign match = (key_reg == look_key);
endmodule

FILE: rtl/core/slru_chain.sv
// A recency chain of cells; front is cell 0. Each cell takes from its
// front neighbour on shift, from its back neighbour on pull. Depends on slru_pkg, slru_cell.
module slru_chain #(
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic [DEPTH-1:0]         shift,
    input  logic [DEPTH-1:0]         pull,
    input  logic [31:0]              front_key,
    input  logic [31:0]              front_value,
    input  logic [31:0]              look_key,
    output logic [DEPTH-1:0][31:0]   keys,
    output logic [DEPTH-1:0][31:0]   values,
    output logic [DEPTH-1:0]         match
);
    import slru_pkg::*;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [31:0] ik;
            logic [31:0] iv;
            logic [31:0] bk;
            logic [31:0] bv;
            if (g == 0)
            begin : g_front
                assign ik = front_key;
                assign iv = front_value;
            end
            else
            begin : g_rest
                assign ik = keys[g-1];
                assign iv = values[g-1];
            end
            // the tail cell has nothing behind it: hold its own word
            if (g == DEPTH - 1)
            begin : g_last
                assign bk = keys[g];
                assign bv = values[g];
            end
            else
            begin : g_inner
                assign bk = keys[g+1];
                assign bv = values[g+1];
            end
            slru_cell u_cell (
                .clk       (clk),
                .shift     (shift[g]),
                .pull      (pull[g]),
                .in_key    (ik),
                .in_value  (iv),
                .back_key  (bk),
                .back_value(bv),
                .look_key  (look_key),
                .key       (keys[g]),
                .value     (values[g]),
                .match     (match[g])
            );
        end
    endgenerate
endmodule

FILE: rtl/core/segmented_lru_cache_top.sv
// Segmented LRU cache: handles one request at a time; in_stall is high until its result is taken.
// The accepting edge registers the cells' parallel key compare; the next edge
// updates the chains as the request needs and registers the result word, valid from then on.
// The result word is held while out_stall is high. Reset (async, rst_n low) empties
// both segments and sets total 8, protected 4; stored words are not cleared.
module segmented_lru_cache_top #(
    parameter int CAPACITY = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  slru_pkg::req_word_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output slru_pkg::rsp_word_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [3:0]            cfg_data
);
    import slru_pkg::*;

    localparam int PD = CAPACITY - 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(PD + 1);
    localparam int MW = $clog2(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]     state_reg;
    logic [3:0]     tcap_reg;
    logic [2:0]     pcap_reg;
    req_word_t      req_reg;
    rsp_word_t      rsp_reg;
    logic [PW-1:0]  pcnt_reg;
    logic [CW-1:0]  mcnt_reg;
    logic [PD-1:0]  pm_reg;
    logic [CAPACITY-1:0] mm_reg;

    logic [PD-1:0][31:0]       pkeys, pvals;
    logic [CAPACITY-1:0][31:0] mkeys, mvals;
    logic [PD-1:0]             pmatch;
    logic [CAPACITY-1:0]       mmatch;
    logic [PD-1:0]             pshift;
    logic [PD-1:0]             ppull;
    logic [CAPACITY-1:0]       mshift;
    logic [CAPACITY-1:0]       mpull;
    slru_cmd_t                 cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = rsp_reg;
    assign ppull     = '0;

    slru_chain #(.DEPTH(PD)) u_prot (
        .clk(clk), .shift(pshift), .pull(ppull),
        .front_key(cmd.p_key), .front_value(cmd.p_value),
        .look_key(in_data.key), .keys(pkeys), .values(pvals), .match(pmatch)
    );
    slru_chain #(.DEPTH(CAPACITY)) u_main (
        .clk(clk), .shift(mshift), .pull(mpull),
        .front_key(cmd.m_key), .front_value(cmd.m_value),
        .look_key(in_data.key), .keys(mkeys), .values(mvals), .match(mmatch)
    );

    // Decision logic: evaluated in ST_LOOK from registered match vectors.
    logic [3:0]    tcap;
    logic [2:0]    pcap;
    logic [PD-1:0] pvalid, phit;
    logic [CAPACITY-1:0] mvalid, mhit;
    logic          p_any, m_any, upd, demote;
    logic [PW-1:0] pidx, pnew, ptail;
    logic [CW-1:0] midx, mnew;
    logic [MW-1:0] mtail;
    logic [31:0]   hval, nval;
    logic [CW:0]   occ;
    rsp_word_t     rsp;

    always_comb
    begin
        tcap = tcap_reg;
        if (tcap < 4'd2) tcap = 4'd2;
        if (32'(tcap) > CAPACITY) tcap = 4'(CAPACITY);
        pcap = (pcap_reg == 3'd0) ? 3'd1 : pcap_reg;
        if (4'(pcap) > tcap - 4'd1) pcap = 3'(tcap - 4'd1);

        for (int i = 0; i < PD; i++) pvalid[i] = (PW'(i) < pcnt_reg);
        for (int i = 0; i < CAPACITY; i++) mvalid[i] = (CW'(i) < mcnt_reg);
        phit = pm_reg & pvalid;
        mhit = mm_reg & mvalid;
        p_any = |phit;
        m_any = |mhit && !p_any;
        pidx = '0;
        hval = '0;
        for (int i = PD - 1; i >= 0; i--)
            if (phit[i]) begin pidx = PW'(i); hval = pvals[i]; end
        midx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (mhit[i]) begin midx = CW'(i); if (!p_any) hval = mvals[i]; end
        upd  = (req_reg.req_type == REQ_GET) || (req_reg.req_type == REQ_PUT);
        nval = (req_reg.req_type == REQ_PUT) ? req_reg.value : hval;
        demote = m_any && upd && (32'(pcnt_reg) >= 32'(pcap)) && (pcnt_reg != '0);
        ptail = pcnt_reg - PW'(1);
        mtail = MW'(mcnt_reg - CW'(1));

        pshift = '0;
        mshift = '0;
        mpull  = '0;
        cmd = '0;
        cmd.p_key = req_reg.key;
        cmd.p_value = nval;
        cmd.m_key = req_reg.key;
        cmd.m_value = req_reg.value;
        pnew = pcnt_reg;
        mnew = mcnt_reg;
        occ = '0;
        rsp = '0;
        rsp.hit = p_any || m_any;
        rsp.was_protected = p_any;
        if ((p_any || m_any) && req_reg.req_type == REQ_GET) rsp.read_value = hval;

        if (state_reg == ST_LOOK)
        begin
            if (p_any && upd)
            begin
                for (int i = 0; i < PD; i++) pshift[i] = (PW'(i) <= pidx);
            end
            else if (m_any && upd)
            begin
                if (demote)
                begin
                    // drop the protected tail into the main front over the hit slot
                    cmd.m_key   = pkeys[ptail];
                    cmd.m_value = pvals[ptail];
                    for (int i = 0; i < CAPACITY; i++) mshift[i] = (CW'(i) <= midx);
                    for (int i = 0; i < PD; i++) pshift[i] = 1'b1;
                end
                else
                begin
                    // close the gap: cells from the hit slot back take their back neighbour
                    for (int i = 0; i < CAPACITY; i++) mpull[i] = (CW'(i) >= midx);
                    for (int i = 0; i < PD; i++) pshift[i] = 1'b1;
                    pnew = pcnt_reg + PW'(1);
                    mnew = mcnt_reg - CW'(1);
                end
            end
            else if (!p_any && !m_any)
            begin
                if (req_reg.req_type == REQ_GET) rsp.miss_error = 1'b1;
                else if (req_reg.req_type == REQ_PUT)
                begin
                    occ = {1'b0, CW'(pcnt_reg)} + {1'b0, mcnt_reg};
                    mnew = mcnt_reg + CW'(1);
                    if (32'(occ) >= 32'(tcap))
                    begin
                        if (mcnt_reg != '0)
                        begin
                            rsp.evicted_valid = 1'b1;
                            rsp.evicted_key = mkeys[mtail];
                            mnew = mcnt_reg;
                        end
                        else if (pcnt_reg != '0)
                        begin
                            rsp.evicted_valid = 1'b1;
                            rsp.evicted_key = pkeys[ptail];
                            pnew = pcnt_reg - PW'(1);
                        end
                    end
                    mshift = '1;
                end
            end
        end
        occ = {1'b0, CW'(pnew)} + {1'b0, mnew};
        rsp.occupancy = 4'(occ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tcap_reg  <= 4'd8;
            pcap_reg  <= 3'd4;
            pcnt_reg  <= '0;
            mcnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TOTAL) tcap_reg <= cfg_data;
                else                        pcap_reg <= cfg_data[2:0];
            end
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid) state_reg <= ST_LOOK;
                ST_LOOK:
                begin
                    pcnt_reg  <= pnew;
                    mcnt_reg  <= mnew;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                    if (!out_stall) state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            req_reg <= in_data;
            pm_reg  <= pmatch;
            mm_reg  <= mmatch;
        end
        if (state_reg == ST_LOOK) rsp_reg <= rsp;
    end
endmodule

FILE: rtl/core/slru_checker.sv
// Port-level checks for the segmented LRU cache; bound to the top level.
// Depends on slru_pkg.
module slru_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input slru_pkg::rsp_word_t out_data
);
    import slru_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed under stall");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while result pending");
    a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result word issued in the cycle after accept");
    a_miss_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.miss_error && out_data.hit))
        else $error("miss and hit together");
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.occupancy <= 4'd8)
        else $error("occupancy out of range");
endmodule

bind segmented_lru_cache_top slru_checker u_slru_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
